// ===== sv/sjfq_pkg.sv =====
// Shared constants, codes and types of the shortest-job-first queue.
package sjfq_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths of one item.
  localparam int TAG_W    = 8;
  localparam int EM_W     = 10;
  localparam int COST_W   = 33;
  localparam int STATUS_W = 2;
  localparam int QCOUNT_W = 5;

  // Glyph counts of the two character sets.
  localparam logic [7:0] GLYPHS_ASCII  = 8'd96;
  localparam logic [7:0] GLYPHS_LATIN1 = 8'd224;

  // Item kinds on the input side.
  localparam logic MODE_SUBMIT = 1'b0;
  localparam logic MODE_TAKE   = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Per-cell load controls.
  typedef struct packed {
    logic load_new;   // store the incoming job
    logic load_next;  // take the neighbor's entry
  } cell_ctl_t;

endpackage

// ===== sv/sjfq_cell.sv =====
// One queue cell: holds a job tag and cost and hands them along the chain.
module sjfq_cell (
  input  logic                       clk,
  input  sjfq_pkg::cell_ctl_t        ctl,
  input  logic [sjfq_pkg::TAG_W-1:0]  new_tag,
  input  logic [sjfq_pkg::COST_W-1:0] new_cost,
  input  logic [sjfq_pkg::TAG_W-1:0]  next_tag,
  input  logic [sjfq_pkg::COST_W-1:0] next_cost,
  output logic [sjfq_pkg::TAG_W-1:0]  tag,
  output logic [sjfq_pkg::COST_W-1:0] cost
);
  import sjfq_pkg::*;

  logic [TAG_W-1:0]  tag_r;
  logic [COST_W-1:0] cost_r;

  // A new job has priority; otherwise the cell takes its neighbor's entry.
  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      tag_r  <= new_tag;
      cost_r <= new_cost;
    end else if (ctl.load_next) begin
      tag_r  <= next_tag;
      cost_r <= next_cost;
    end
  end

  assign tag  = tag_r;
  assign cost = cost_r;

endmodule

// ===== sv/sjfq_cost.sv =====
// Three-stage job cost unit: glyphs times em size squared times atlas factor.
module sjfq_cost (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        latin1,
  input  logic                        mtsdf,
  input  logic [sjfq_pkg::EM_W-1:0]   em_size,
  output logic                        done,
  output logic [sjfq_pkg::COST_W-1:0] cost
);
  import sjfq_pkg::*;

  localparam int SQ_W   = 2 * EM_W;
  localparam int PROD_W = SQ_W + 8;

  logic [2:0]        vld_r;
  logic [SQ_W-1:0]   sq_r;
  logic [7:0]        glyphs_r;
  logic              mtsdf1_r;
  logic              mtsdf2_r;
  logic [PROD_W-1:0] prod_r;
  logic [COST_W-1:0] cost_r;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 3'b000;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
  end

  // Square, then glyph count, then the factor of 20 as 16 plus 4.
  always_ff @(posedge clk) begin
    sq_r     <= SQ_W'(em_size) * SQ_W'(em_size);
    glyphs_r <= latin1 ? GLYPHS_LATIN1 : GLYPHS_ASCII;
    mtsdf1_r <= mtsdf;
    prod_r   <= PROD_W'(sq_r) * PROD_W'(glyphs_r);
    mtsdf2_r <= mtsdf1_r;
    if (mtsdf2_r) begin
      cost_r <= (COST_W'(prod_r) << 4) + (COST_W'(prod_r) << 2);
    end else begin
      cost_r <= COST_W'(prod_r);
    end
  end

  assign done = vld_r[2];
  assign cost = cost_r;

endmodule

// ===== sv/shortest_job_first_queue.sv =====
// Shortest-job-first queue top level: control, chain of cells and result register.
// A submit waits in the cost state for the cost unit before its result is posted;
// a full-queue submit or an empty-queue take goes straight to posting. A take runs the
// scan that rotates the cell ring once past the minimum comparator, then the removal.
// One item is worked on at a time; the next is accepted once the result is posted.
// Synchronous reset empties the queue; cell contents are left as they are.
module shortest_job_first_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // job_tag[7:0], charset_latin1[8], atlas_mtsdf[9],
                                  // em_pixel_size[19:10], zero fill
  input  logic        in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // taken_tag[7:0], taken_cost[40:8],
                                  // queued_count[45:41], zero fill
  output logic [1:0]  out_tuser   // status[1:0]
);
  import sjfq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_COST   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_REMOVE = 3'd3;
  localparam logic [2:0] S_POST   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    scan_k_r, scan_k_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [TAG_W-1:0]    best_tag_r, best_tag_nxt;
  logic [COST_W-1:0]   best_cost_r, best_cost_nxt;
  logic [TAG_W-1:0]    job_tag_r, job_tag_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [TAG_W-1:0]    res_tag_r, res_tag_nxt;
  logic [COST_W-1:0]   res_cost_r, res_cost_nxt;
  logic                out_valid_r;
  logic [47:0]         out_data_r;
  logic [STATUS_W-1:0] out_status_r;

  logic              accept;
  logic              in_mode;
  logic              cost_start;
  logic              cost_done;
  logic [COST_W-1:0] new_cost;
  logic              take_head;
  logic              post;

  cell_ctl_t         ctl    [QUEUE_DEPTH];
  logic [TAG_W-1:0]  tags   [QUEUE_DEPTH];
  logic [COST_W-1:0] costs  [QUEUE_DEPTH];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_mode   = in_tuser;
  assign cost_start = accept && (in_mode == MODE_SUBMIT) &&
                      (count_r != CNT_W'(QUEUE_DEPTH));
  assign post = (state_r == S_POST) && (!out_valid_r || out_tready);

  // Cost unit for submitted jobs.
  sjfq_cost u_cost (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cost_start),
    .latin1  (in_tdata[8]),
    .mtsdf   (in_tdata[9]),
    .em_size (in_tdata[19:10]),
    .done    (cost_done),
    .cost    (new_cost)
  );

  // Ring of cells; each one takes from the next, the last from the first.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign ctl[i].load_new  = cost_done && (count_r == CNT_W'(i));
    assign ctl[i].load_next = (state_r == S_SCAN) ||
                              ((state_r == S_REMOVE) && (IDX_W'(i) >= best_idx_r));
    sjfq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .new_tag   (job_tag_r),
      .new_cost  (new_cost),
      .next_tag  (tags[(i + 1) % QUEUE_DEPTH]),
      .next_cost (costs[(i + 1) % QUEUE_DEPTH]),
      .tag       (tags[i]),
      .cost      (costs[i])
    );
  end

  // The head cell holds entry k during step k of the scan; earliest wins ties.
  assign take_head = (scan_k_r == '0) ||
                     ((CNT_W'(scan_k_r) < count_r) && (costs[0] < best_cost_r));

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_k_nxt     = scan_k_r;
    best_idx_nxt   = best_idx_r;
    best_tag_nxt   = best_tag_r;
    best_cost_nxt  = best_cost_r;
    job_tag_nxt    = job_tag_r;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    res_cost_nxt   = res_cost_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_DONE;
          res_tag_nxt    = '0;
          res_cost_nxt   = '0;
          job_tag_nxt    = in_tdata[7:0];
          scan_k_nxt     = '0;
          if (in_mode == MODE_SUBMIT) begin
            if (count_r == CNT_W'(QUEUE_DEPTH)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_POST;
            end else begin
              state_nxt = S_COST;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_POST;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_COST: begin
        if (cost_done) begin
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_POST;
        end
      end
      S_SCAN: begin
        if (take_head) begin
          best_idx_nxt  = scan_k_r;
          best_tag_nxt  = tags[0];
          best_cost_nxt = costs[0];
        end
        scan_k_nxt = scan_k_r + IDX_W'(1);
        if (scan_k_r == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_nxt = S_REMOVE;
        end
      end
      S_REMOVE: begin
        res_tag_nxt  = best_tag_r;
        res_cost_nxt = best_cost_r;
        count_nxt    = count_r - CNT_W'(1);
        state_nxt    = S_POST;
      end
      S_POST: begin
        if (post) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      scan_k_r <= scan_k_nxt;
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    best_idx_r   <= best_idx_nxt;
    best_tag_r   <= best_tag_nxt;
    best_cost_r  <= best_cost_nxt;
    job_tag_r    <= job_tag_nxt;
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    res_cost_r   <= res_cost_nxt;
    if (post) begin
      out_status_r <= res_status_r;
      out_data_r   <= {2'b00, QCOUNT_W'(count_r), res_cost_r, res_tag_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // A scan only runs over a non-empty queue.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (count_r != '0))
    else $error("scan started on an empty queue");

  // Removal drops exactly one entry.
  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REMOVE) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("removal did not drop one entry");

  // A finished cost always lands in a free cell and adds one entry.
  a_cost_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cost_done |-> ((state_r == S_COST) && (count_r < CNT_W'(QUEUE_DEPTH))))
    else $error("cost finished outside a submit or into a full queue");

endmodule
